### src/tdfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdfs_pkg
// Shared types and constants for the timer divider factor search block.
// ----------------------------------------------------------------------------
package tdfs_pkg;

	localparam int DIVIDER_BITS_DEF = 16;
	// Working width of the divider: 2*clock + rate needs 34 bits
	localparam int WIDE_W = 34;
	localparam logic [31:0] CLOCK_RESET = 32'd72000000;

	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	typedef enum logic [1:0] {
		DIV_TGT,
		DIV_SRCH,
		DIV_ACH
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_TGT_WAIT,
		S_RANGE,
		S_SRCH_START,
		S_SRCH_WAIT,
		S_ACH_START,
		S_ACH_WAIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic       cap_in;
		logic       div_start;
		div_sel_t   div_sel;
		logic       cap_tgt;
		logic       init_d;
		logic       inc_d;
		logic       cap_q;
		logic       set_status;
		logic [1:0] status;
		logic       load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rate_zero;
		logic div_done;
		logic tgt_zero;
		logic range_empty;
		logic hit;
		logic d_last;
		logic out_free;
	} dp_stat_t;

endpackage

### src/tdfs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdfs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdfs_div #(
	parameter int W = tdfs_pkg::WIDE_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     quo_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [W:0]   rem_sh;
	logic         ge;
	logic [W:0]   rem_diff;
	logic [W-1:0] rem_nx;

	always_comb begin
		rem_sh   = {rem_q, quo_q[W-1]};
		ge       = rem_sh >= {1'b0, dvs_q};
		rem_diff = rem_sh - {1'b0, dvs_q};
		rem_nx   = ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### src/tdfs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdfs_dp
// Datapath: clock register, ratio and divisor registers, shared divider,
// result register.
// ----------------------------------------------------------------------------
module tdfs_dp #(
	parameter int DIVIDER_BITS = tdfs_pkg::DIVIDER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [31:0]          cfg_wr_data,
	input  logic [31:0]          wanted_rate_hz,
	input  tdfs_pkg::ctrl_cmd_t  cmd,
	output tdfs_pkg::dp_stat_t   stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [15:0]          prescaler,
	output logic [15:0]          reload,
	output logic [31:0]          achieved_rate_hz
);

	localparam int WW = tdfs_pkg::WIDE_W;
	localparam int DW = DIVIDER_BITS + 1;
	localparam logic [WW-1:0] QMAX = WW'(1) << DIVIDER_BITS;
	localparam logic [WW-1:0] DMAX = QMAX - WW'(1);

	logic [31:0]   clk_hz_q;
	logic [31:0]   rate_q;
	logic [31:0]   target_q;
	logic [DW-1:0] d_q;
	logic [32:0]   q_q;
	logic [1:0]    res_status_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [15:0]   prescaler_q;
	logic [15:0]   reload_q;
	logic [31:0]   achieved_q;

	logic [WW-1:0] div_a;
	logic [WW-1:0] div_b;
	logic          div_busy;
	logic          div_done;
	logic [WW-1:0] div_quo;
	logic [WW-1:0] div_rem;

	logic [WW-1:0] tgt_w;
	logic [WW-1:0] dlo;
	logic [WW-1:0] dhi;
	logic [WW-1:0] d_w;
	logic [WW-1:0] psc_w;
	logic [WW-1:0] rld_w;
	logic          out_free;

	always_comb begin
		case (cmd.div_sel)
			tdfs_pkg::DIV_TGT: begin
				div_a = (WW'(clk_hz_q) << 1) + WW'(rate_q);
				div_b = WW'(rate_q) << 1;
			end
			tdfs_pkg::DIV_SRCH: begin
				div_a = WW'(target_q);
				div_b = WW'(d_q);
			end
			tdfs_pkg::DIV_ACH: begin
				div_a = WW'(clk_hz_q);
				div_b = WW'(target_q);
			end
			default: begin
				div_a = '0;
				div_b = '0;
			end
		endcase
	end

	tdfs_div #(.W(WW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// First usable divisor is ceil(target / qmax); last is min(dmax, target)
	always_comb begin
		tgt_w = WW'(target_q);
		dlo   = (tgt_w + DMAX) >> DIVIDER_BITS;
		dhi   = (tgt_w < DMAX) ? tgt_w : DMAX;
		d_w   = WW'(d_q);
		psc_w = d_w - WW'(1);
		rld_w = WW'(q_q) - WW'(1);
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		stat.rate_zero   = (rate_q == '0);
		stat.div_done    = div_done;
		stat.tgt_zero    = (target_q == '0);
		stat.range_empty = (dlo > dhi);
		stat.hit         = (div_rem == '0) && (div_quo <= QMAX);
		stat.d_last      = (d_w == dhi);
		stat.out_free    = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q    <= tdfs_pkg::CLOCK_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				clk_hz_q <= cfg_wr_data;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			rate_q <= wanted_rate_hz;
		end
		if (cmd.cap_tgt) begin
			target_q <= div_quo[31:0];
		end
		if (cmd.init_d) begin
			d_q <= dlo[DW-1:0];
		end else if (cmd.inc_d) begin
			d_q <= d_q + DW'(1);
		end
		if (cmd.cap_q) begin
			q_q <= div_quo[32:0];
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status;
		end
		if (cmd.load_out) begin
			status_q <= res_status_q;
			if (res_status_q == tdfs_pkg::ST_FOUND) begin
				prescaler_q <= psc_w[15:0];
				reload_q    <= rld_w[15:0];
				achieved_q  <= div_quo[31:0];
			end else begin
				prescaler_q <= '0;
				reload_q    <= '0;
				achieved_q  <= '0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign prescaler        = prescaler_q;
	assign reload           = reload_q;
	assign achieved_rate_hz = achieved_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider started while busy");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free)
		else $error("result register overwritten");
	a_inc_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.inc_d |-> !stat.d_last)
		else $error("divisor stepped past upper bound");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != tdfs_pkg::ST_FOUND) |->
		(prescaler_q == '0 && reload_q == '0 && achieved_q == '0))
		else $error("failed result carries nonzero fields");
`endif

endmodule

### src/tdfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdfs_ctrl
// Sequencer: ratio division, divisor search loop, achieved-rate division.
// ----------------------------------------------------------------------------
module tdfs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tdfs_pkg::dp_stat_t   stat,
	output tdfs_pkg::ctrl_cmd_t  cmd
);

	tdfs_pkg::state_t state_q;
	tdfs_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdfs_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tdfs_pkg::S_IDLE: begin
				if (in_valid) state_nx = tdfs_pkg::S_CHECK;
			end
			tdfs_pkg::S_CHECK: begin
				state_nx = stat.rate_zero ? tdfs_pkg::S_FINISH : tdfs_pkg::S_TGT_WAIT;
			end
			tdfs_pkg::S_TGT_WAIT: begin
				if (stat.div_done) state_nx = tdfs_pkg::S_RANGE;
			end
			tdfs_pkg::S_RANGE: begin
				if (stat.tgt_zero || stat.range_empty) begin
					state_nx = tdfs_pkg::S_FINISH;
				end else begin
					state_nx = tdfs_pkg::S_SRCH_START;
				end
			end
			tdfs_pkg::S_SRCH_START: begin
				state_nx = tdfs_pkg::S_SRCH_WAIT;
			end
			tdfs_pkg::S_SRCH_WAIT: begin
				if (stat.div_done) begin
					if (stat.hit) begin
						state_nx = tdfs_pkg::S_ACH_START;
					end else if (stat.d_last) begin
						state_nx = tdfs_pkg::S_FINISH;
					end else begin
						state_nx = tdfs_pkg::S_SRCH_START;
					end
				end
			end
			tdfs_pkg::S_ACH_START: begin
				state_nx = tdfs_pkg::S_ACH_WAIT;
			end
			tdfs_pkg::S_ACH_WAIT: begin
				if (stat.div_done) state_nx = tdfs_pkg::S_FINISH;
			end
			tdfs_pkg::S_FINISH: begin
				if (stat.out_free) state_nx = tdfs_pkg::S_IDLE;
			end
			default: begin
				state_nx = tdfs_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.div_sel  = tdfs_pkg::DIV_TGT;
		cmd.status   = tdfs_pkg::ST_NOTFOUND;
		in_ready     = 1'b0;
		case (state_q)
			tdfs_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.cap_in = in_valid;
			end
			tdfs_pkg::S_CHECK: begin
				if (stat.rate_zero) begin
					cmd.set_status = 1'b1;
					cmd.status     = tdfs_pkg::ST_INVALID;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			tdfs_pkg::S_TGT_WAIT: begin
				cmd.cap_tgt = stat.div_done;
			end
			tdfs_pkg::S_RANGE: begin
				if (stat.tgt_zero || stat.range_empty) begin
					cmd.set_status = 1'b1;
				end else begin
					cmd.init_d = 1'b1;
				end
			end
			tdfs_pkg::S_SRCH_START: begin
				cmd.div_sel   = tdfs_pkg::DIV_SRCH;
				cmd.div_start = 1'b1;
			end
			tdfs_pkg::S_SRCH_WAIT: begin
				cmd.div_sel = tdfs_pkg::DIV_SRCH;
				if (stat.div_done) begin
					if (stat.hit) begin
						cmd.cap_q = 1'b1;
					end else if (stat.d_last) begin
						cmd.set_status = 1'b1;
					end else begin
						cmd.inc_d = 1'b1;
					end
				end
			end
			tdfs_pkg::S_ACH_START: begin
				cmd.div_sel   = tdfs_pkg::DIV_ACH;
				cmd.div_start = 1'b1;
			end
			tdfs_pkg::S_ACH_WAIT: begin
				cmd.div_sel = tdfs_pkg::DIV_ACH;
				if (stat.div_done) begin
					cmd.set_status = 1'b1;
					cmd.status     = tdfs_pkg::ST_FOUND;
				end
			end
			tdfs_pkg::S_FINISH: begin
				cmd.div_sel  = tdfs_pkg::DIV_ACH;
				cmd.load_out = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### src/timer_divider_factor_search.sv
`timescale 1ns / 1ps
// Sequence: a zero rate finishes at once; a zero ratio or no divisor in range finishes after the ratio division;
//   else one divider pass per divisor tried, plus the achieved-rate pass on a match (N tried, N < 2^DIVIDER_BITS).
// Each divider pass: start, 34 quotient bits (one per cycle), done.
// Throughput: one request at a time; the next is taken once the result is registered,
//   and a result still stalled holds the next one back from the result register until it is taken.
// Reset (arst_n low, asynchronous): idle, no result pending, clock register = 72 MHz.
// ----------------------------------------------------------------------------
// timer_divider_factor_search
// Finds timer prescaler and reload values for a wanted trigger rate.
// ----------------------------------------------------------------------------
module timer_divider_factor_search #(
	parameter int DIVIDER_BITS = tdfs_pkg::DIVIDER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] wanted_rate_hz,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] prescaler,
	output logic [15:0] reload,
	output logic [31:0] achieved_rate_hz
);

	tdfs_pkg::ctrl_cmd_t cmd;
	tdfs_pkg::dp_stat_t  stat;

	tdfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tdfs_dp #(.DIVIDER_BITS(DIVIDER_BITS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.wanted_rate_hz   (wanted_rate_hz),
		.cmd              (cmd),
		.stat             (stat),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.prescaler        (prescaler),
		.reload           (reload),
		.achieved_rate_hz (achieved_rate_hz)
	);

endmodule

### tb/timer_divider_factor_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_divider_factor_search_checker
// Watches the request, result and clock register ports, computes the timer
// setting each request should produce and compares it with each result beat.
// ----------------------------------------------------------------------------
module timer_divider_factor_search_checker #(
	parameter int DIVIDER_BITS = tdfs_pkg::DIVIDER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] wanted_rate_hz,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [15:0] prescaler,
	input  logic [15:0] reload,
	input  logic [31:0] achieved_rate_hz,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] prescaler;
		logic [15:0] reload;
		logic [31:0] achieved;
	} timer_setting_t;

	logic [31:0]    clock_hz;
	timer_setting_t settings_q[$];
	timer_setting_t got;
	timer_setting_t want;
	int unsigned    fail_count = 0;

	assign mismatches = fail_count;

	// First divisor from the lowest usable one up that splits the ratio exactly.
	function automatic timer_setting_t plan_timer(logic [31:0] rate, logic [31:0] clock);
		timer_setting_t plan;
		logic [63:0]    target;
		logic [63:0]    qmax;
		logic [63:0]    dlo;
		logic [63:0]    dhi;
		logic [63:0]    d;
		logic [63:0]    q;
		plan = '0;
		plan.status = tdfs_pkg::ST_INVALID;
		if (rate == 32'd0)
			return plan;
		plan.status = tdfs_pkg::ST_NOTFOUND;
		target = (2 * {32'd0, clock} + {32'd0, rate}) / (2 * {32'd0, rate});
		if (target == 64'd0)
			return plan;
		qmax = 64'd1 << DIVIDER_BITS;
		dlo = (target + qmax - 64'd1) / qmax;
		if (dlo == 64'd0)
			dlo = 64'd1;
		dhi = (qmax - 64'd1 < target) ? qmax - 64'd1 : target;
		for (d = dlo; d <= dhi; d++) begin
			q = target / d;
			if (q * d == target && q <= qmax) begin
				plan.status    = tdfs_pkg::ST_FOUND;
				plan.prescaler = 16'(d - 64'd1);
				plan.reload    = 16'(q - 64'd1);
				plan.achieved  = 32'({32'd0, clock} / target);
				return plan;
			end
		end
		return plan;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz <= tdfs_pkg::CLOCK_RESET;
			outstanding <= 0;
		end else begin
			if (cfg_wr_en)
				clock_hz <= cfg_wr_data;
			if (in_valid && in_ready)
				settings_q.push_back(plan_timer(wanted_rate_hz, clock_hz));
			if (out_valid && out_ready) begin
				got = {status, prescaler, reload, achieved_rate_hz};
				if (settings_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected beat: status %0d prescaler %0d reload %0d rate %0d",
							$realtime, got.status, got.prescaler, got.reload, got.achieved);
				end else begin
					want = settings_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch: expected status %0d prescaler %0d reload %0d rate %0d",
								$realtime, want.status, want.prescaler, want.reload, want.achieved);
							$display("%0t:           got status %0d prescaler %0d reload %0d rate %0d",
								$realtime, got.status, got.prescaler, got.reload, got.achieved);
						end
					end
				end
			end
			outstanding <= settings_q.size();
		end
	end

endmodule

### tb/timer_divider_factor_search_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_divider_factor_search_test
// Drives rate requests through several clock register settings (reset value,
// extremes, zero, random) with random gaps and result stalls; the checker
// predicts every timer setting and counts mismatches.
// ----------------------------------------------------------------------------
module timer_divider_factor_search_test;

	localparam int          DIVIDER_BITS = tdfs_pkg::DIVIDER_BITS_DEF;
	// random requests whose search would try more divisors than this are redrawn
	localparam int unsigned SPAN_CAP     = 300;
	localparam int unsigned CYCLE_LIMIT  = 8000000;
	localparam int unsigned TAIL_CYCLES  = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] wanted_rate_hz = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [15:0] prescaler;
	logic [15:0] reload;
	logic [31:0] achieved_rate_hz;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	logic [31:0] clock_setting = tdfs_pkg::CLOCK_RESET;
	logic        steady = 1'b0;

	always #6 clk = ~clk;

	timer_divider_factor_search #(
		.DIVIDER_BITS(DIVIDER_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.wanted_rate_hz(wanted_rate_hz),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.prescaler(prescaler),
		.reload(reload),
		.achieved_rate_hz(achieved_rate_hz)
	);

	timer_divider_factor_search_checker #(
		.DIVIDER_BITS(DIVIDER_BITS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.wanted_rate_hz(wanted_rate_hz),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.prescaler(prescaler),
		.reload(reload),
		.achieved_rate_hz(achieved_rate_hz),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// Number of divisors the block walks through for this rate, capped just past SPAN_CAP.
	function automatic int unsigned divisors_tried(logic [31:0] rate);
		logic [63:0] target;
		logic [63:0] qmax;
		logic [63:0] dlo;
		logic [63:0] dhi;
		logic [63:0] d;
		int unsigned n;
		n = 0;
		if (rate == 32'd0)
			return 0;
		target = (2 * {32'd0, clock_setting} + {32'd0, rate}) / (2 * {32'd0, rate});
		qmax = 64'd1 << DIVIDER_BITS;
		dlo = (target + qmax - 64'd1) / qmax;
		if (dlo == 64'd0)
			dlo = 64'd1;
		dhi = (qmax - 64'd1 < target) ? qmax - 64'd1 : target;
		for (d = dlo; d <= dhi && n <= SPAN_CAP; d++) begin
			n++;
			if (target % d == 64'd0 && target / d <= qmax)
				return n;
		end
		return n;
	endfunction

	task automatic send_rate(input logic [31:0] rate);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		wanted_rate_hz <= rate;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pick_rate(output logic [31:0] rate);
		int unsigned attempt;
		for (attempt = 0; attempt < 50; attempt++) begin
			case ($urandom_range(0, 7))
				0: rate = 32'd0;
				1: rate = $urandom();
				2, 3: rate = $urandom_range(1, 4096);
				default: rate = $urandom() >> $urandom_range(0, 31);
			endcase
			if (divisors_tried(rate) <= SPAN_CAP)
				return;
		end
		// ratio of at most two: at most one divisor tried
		rate = $urandom() | 32'h8000_0000;
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned i;
		logic [31:0] rate;
		for (i = 0; i < count; i++) begin
			if (i % 16 == 0)
				steady = ($urandom_range(0, 3) == 0);
			pick_rate(rate);
			send_rate(rate);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// register writes only land while no request is in flight
	task automatic set_clock(input logic [31:0] value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		clock_setting = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stall before each beat
	initial begin
		int unsigned stall;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset clock of 72 MHz
		send_rate(32'd0);
		send_rate(32'd1);
		send_rate(32'd1098);
		send_rate(32'd1099);
		send_rate(32'd1100);
		send_rate(32'd65535);
		send_rate(32'd48000000);
		send_rate(32'd72000000);
		send_rate(32'd144000000);
		send_rate(32'd144000001);
		send_rate(32'h8000_0000);
		send_rate(32'h5555_5555);
		send_rate(32'hAAAA_AAAA);
		send_rate(32'hFFFF_FFFF);
		run_random(20);

		// widest clock: empty divisor range, quotient of exactly 2^16, ratio of one
		set_clock(32'hFFFF_FFFF);
		send_rate(32'd1);
		send_rate(32'd2);
		send_rate(32'hFFFF_FFFF);
		run_random(15);

		// one divisor in range and it does not divide
		set_clock(32'd4294901759);
		send_rate(32'd1);
		run_random(5);

		set_clock(32'd1);
		send_rate(32'd1);
		send_rate(32'd2);
		send_rate(32'd3);
		run_random(5);

		set_clock(32'd0);
		send_rate(32'd0);
		send_rate(32'd5);
		send_rate(32'hFFFF_FFFF);
		run_random(3);

		set_clock($urandom());
		run_random(12);
		set_clock($urandom());
		run_random(12);

		set_clock(tdfs_pkg::CLOCK_RESET);
		run_random(10);

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
